@@ rtl/dq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types, codes and sizes for the double-ended queue core.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int CAPACITY = 16;
    localparam int WORD_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    // operation codes; unused codes behave as peek
    localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [2:0] MODE_PUSH_REAR  = 3'd1;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [2:0] MODE_POP_REAR   = 3'd3;
    localparam logic [2:0] MODE_PEEK       = 3'd4;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

    typedef struct packed {
        logic [2:0]               mode;
        logic signed [WORD_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] rear_value;
        logic [CNT_W-1:0]         count;
    } out_item_t;

    // per-cell update control
    typedef struct packed {
        logic shift_front;  // take the word of the neighbor nearer the front
        logic shift_back;   // take the word of the neighbor nearer the rear
        logic load;         // take the pushed word
    } cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/dq_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dq_cell
// One storage cell of the deque chain: holds one word, takes a neighbor's
// word on a shift or the pushed word on a load, else holds.
// ----------------------------------------------------------------------------
module dq_cell (
    input  wire                              clk,
    input  wire dq_pkg::cell_ctrl_t          ctrl,
    input  wire logic signed [dq_pkg::WORD_W-1:0] push_value,
    input  wire logic signed [dq_pkg::WORD_W-1:0] from_front,
    input  wire logic signed [dq_pkg::WORD_W-1:0] from_rear,
    output logic signed [dq_pkg::WORD_W-1:0] data
);
    import dq_pkg::*;

    logic signed [WORD_W-1:0] data_reg;
    logic signed [WORD_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load)
        begin
            data_next = push_value;
        end
        else if (ctrl.shift_front)
        begin
            data_next = from_front;
        end
        else if (ctrl.shift_back)
        begin
            data_next = from_rear;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
`default_nettype wire

@@ rtl/double_ended_queue_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded deque of signed 32-bit words held in a chain of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive item (mode, value) and raise start. The item is
//   taken at the rising edge where start is high and busy is low. busy stays
//   low, so one item can be taken every cycle.
//   Result channel: done is high for exactly one cycle, the cycle after the
//   item was taken, and result holds status, front and rear words after the
//   operation (-1 when empty) and the element count. Throughput is one item
//   per cycle.
//   Cell 0 always holds the front; cell count-1 holds the rear. Push front
//   shifts the whole chain one cell toward the rear, pop front shifts it one
//   cell toward the front, push rear loads cell count, pop rear only drops
//   the count.
//   Reset empties the deque (count zero) and clears done; cell contents are
//   not reset and are never shown before being written.
//   The receiver cannot stall: each result is valid for its one cycle only.
// ----------------------------------------------------------------------------
module double_ended_queue_core (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              start,
    output logic             busy,
    input  wire dq_pkg::in_item_t item,
    output logic             done,
    output dq_pkg::out_item_t result
);
    import dq_pkg::*;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    logic                accept;
    logic                empty;
    logic                full;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [1:0]          status_reg;
    logic [1:0]          status_next;
    logic                done_reg;

    // shared command decoded once, fanned out to the cells
    logic                do_shift_front;
    logic                do_shift_back;
    logic                do_load_rear;

    cell_ctrl_t               cell_ctrl [CAPACITY];
    logic signed [WORD_W-1:0] cell_data [CAPACITY];
    logic [IDX_W-1:0]         rear_idx;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign empty  = (count_reg == '0);
    assign full   = (count_reg == FULL_CNT);

    always_comb
    begin
        count_next     = count_reg;
        status_next    = STATUS_DONE;
        do_shift_front = 1'b0;
        do_shift_back  = 1'b0;
        do_load_rear   = 1'b0;
        case (item.mode)
            MODE_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    do_shift_front = accept;
                    count_next     = count_reg + 1'b1;
                end
            end
            MODE_PUSH_REAR:
            begin
                if (full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    do_load_rear = accept;
                    count_next   = count_reg + 1'b1;
                end
            end
            MODE_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    do_shift_back = accept;
                    count_next    = count_reg - 1'b1;
                end
            end
            MODE_POP_REAR:
            begin
                if (empty)
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            default:  // peek and unused codes
            begin
                if (empty)
                begin
                    status_next = STATUS_EMPTY;
                end
            end
        endcase
    end

    // per-cell control: push rear loads only the cell just past the rear
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_ctrl[i].shift_front = do_shift_front;
            cell_ctrl[i].shift_back  = do_shift_back;
            cell_ctrl[i].load        = do_load_rear && (count_reg == CNT_W'(i));
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [WORD_W-1:0] from_front;
        logic signed [WORD_W-1:0] from_rear;

        // front cell takes the pushed word on a front shift;
        // rear cell holds on a back shift
        if (g == 0)
        begin : g_first
            assign from_front = item.value;
        end
        else
        begin : g_mid_f
            assign from_front = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign from_rear = cell_data[g];
        end
        else
        begin : g_mid_r
            assign from_rear = cell_data[g+1];
        end

        dq_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl[g]),
            .push_value (item.value),
            .from_front (from_front),
            .from_rear  (from_rear),
            .data       (cell_data[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            status_reg <= STATUS_DONE;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg  <= count_next;
                status_reg <= status_next;
            end
        end
    end

    // result fields come straight from the updated state
    assign rear_idx = IDX_W'(count_reg - 1'b1);

    assign done               = done_reg;
    assign result.status      = status_reg;
    assign result.count       = count_reg;
    assign result.front_value = empty ? EMPTY_WORD : cell_data[0];
    assign result.rear_value  = empty ? EMPTY_WORD : cell_data[rear_idx];

    // ---- assertions ----
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("count beyond capacity");

    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(accept))
        else $error("done without a taken item");

    a_full_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && full && (item.mode == MODE_PUSH_FRONT || item.mode == MODE_PUSH_REAR))
        |=> ($stable(count_reg) && status_reg == STATUS_FULL))
        else $error("push into full deque changed it");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == STATUS_EMPTY) |-> (count_reg == '0))
        else $error("empty status with elements held");

endmodule
`default_nettype wire
